@@ hdl/iucv_pkg.sv @@
// shared types and constants for the ipv6/udp/coap validator
`timescale 1ns / 1ps
`default_nettype none
package iucv_pkg;
  localparam logic [16:0] POS_MAX = 17'd131071;
  localparam logic [16:0] MIN_PACKET = 17'd52;
  localparam logic [16:0] IP_HDR_BYTES = 17'd40;
  localparam logic [7:0] UDP_PROTO = 8'd17;
  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [3:0] EXT_LIMIT = 4'd13;
  localparam logic [15:0] URI_PATH = 16'd11;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SHORT = 4'd1;
  localparam logic [3:0] ST_VERSION = 4'd2;
  localparam logic [3:0] ST_NOT_UDP = 4'd3;
  localparam logic [3:0] ST_IP_TRUNC = 4'd4;
  localparam logic [3:0] ST_UDP_LEN = 4'd5;
  localparam logic [3:0] ST_UDP_TRUNC = 4'd6;
  localparam logic [3:0] ST_COAP_SHORT = 4'd7;
  localparam logic [3:0] ST_COAP_HDR = 4'd8;
  localparam logic [3:0] ST_EXT_OPT = 4'd9;
  localparam logic [3:0] ST_OPT_TRUNC = 4'd10;
  localparam logic [3:0] ST_URI = 4'd11;
  localparam logic [3:0] ST_PAYLOAD = 4'd12;

  // finished packet summary passed from front to back
  typedef struct packed {
    logic [16:0] total;
    logic [3:0]  first_error;
    logic [15:0] ip_payload_length;
    logic        saw_both;
    logic [16:0] payload_start;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] udp_length;
    logic [7:0]  hop_count;
    logic [7:0]  coap_code;
    logic [15:0] message_id;
  } summary_t;

  // result word
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] udp_length;
    logic [7:0]  hop_count;
    logic [7:0]  coap_code;
    logic [15:0] message_id;
  } result_t;

  function automatic logic [7:0] sensor_char(input logic [3:0] k);
    case (k)
      4'd0: sensor_char = 8'h73;
      4'd1: sensor_char = 8'h65;
      4'd2: sensor_char = 8'h6E;
      4'd3: sensor_char = 8'h73;
      4'd4: sensor_char = 8'h6F;
      4'd5: sensor_char = 8'h72;
      default: sensor_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] data_char(input logic [3:0] k);
    case (k)
      4'd0: data_char = 8'h64;
      4'd1: data_char = 8'h61;
      4'd2: data_char = 8'h74;
      4'd3: data_char = 8'h61;
      default: data_char = 8'h00;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ hdl/iucv_front.sv @@
// byte front end: captures header fields and walks coap options
`timescale 1ns / 1ps
`default_nettype none
module iucv_front (
  input  wire                     clk,
  input  wire                     rst,
  input  wire  [7:0]              data_byte,
  input  wire                     last_byte,
  input  wire                     take,
  output logic                    sum_valid,
  output iucv_pkg::summary_t      sum
);
  logic [16:0] byte_position;
  logic [3:0]  first_error;
  logic [15:0] ip_payload_length;
  logic [15:0] sport, dport, ulen, msg_id;
  logic [7:0]  hop, code;
  logic [15:0] option_number;
  logic [3:0]  option_bytes_left;
  logic [3:0]  option_value_index;
  logic [3:0]  match_flags;
  logic [16:0] payload_start;

  logic [16:0] pos_inc;
  logic [16:0] opt_end;
  logic        walk;
  logic [3:0]  err_next;
  logic [15:0] optn_next;
  logic [3:0]  left_next, idx_next, flags_next;
  logic [16:0] pstart_next;
  logic [15:0] ulen_now;
  logic [3:0]  dl, ln;
  logic [15:0] optn_sum;

  assign pos_inc = (byte_position < iucv_pkg::POS_MAX) ? byte_position + 17'd1 : byte_position;
  assign dl = data_byte[7:4];
  assign ln = data_byte[3:0];
  assign optn_sum = option_number + {12'd0, dl};
  assign ulen_now = ulen;
  assign opt_end = iucv_pkg::IP_HDR_BYTES + {1'b0, ulen_now};

  // header checks and option walk for one byte
  always_comb begin
    err_next = first_error;
    optn_next = option_number;
    left_next = option_bytes_left;
    idx_next = option_value_index;
    flags_next = match_flags;
    pstart_next = payload_start;
    if (byte_position == 17'd0 && dl != 4'd6 && err_next == iucv_pkg::ST_OK)
      err_next = iucv_pkg::ST_VERSION;
    if (byte_position == 17'd6 && data_byte != iucv_pkg::UDP_PROTO &&
        err_next == iucv_pkg::ST_OK)
      err_next = iucv_pkg::ST_NOT_UDP;
    if (byte_position == 17'd48 && (data_byte[7:6] != 2'd1 || data_byte[5:4] != 2'd1 ||
        data_byte[3:0] != 4'd0) && err_next == iucv_pkg::ST_OK)
      err_next = iucv_pkg::ST_COAP_HDR;
    walk = byte_position >= iucv_pkg::MIN_PACKET && first_error == iucv_pkg::ST_OK &&
           payload_start == 17'd0 && byte_position < opt_end;
    if (walk) begin
      if (option_bytes_left != 4'd0) begin
        if (match_flags[2] && (option_value_index >= 4'd6 ||
            data_byte != iucv_pkg::sensor_char(option_value_index)))
          flags_next[2] = 1'b0;
        if (match_flags[3] && (option_value_index >= 4'd4 ||
            data_byte != iucv_pkg::data_char(option_value_index)))
          flags_next[3] = 1'b0;
        idx_next = option_value_index + 4'd1;
        left_next = option_bytes_left - 4'd1;
        if (left_next == 4'd0) begin
          flags_next[0] = flags_next[0] | flags_next[2];
          flags_next[1] = flags_next[1] | flags_next[3];
          flags_next[3:2] = 2'b00;
        end
      end else if (data_byte == iucv_pkg::MARKER_BYTE) begin
        pstart_next = byte_position + 17'd1;
      end else if (dl >= iucv_pkg::EXT_LIMIT || ln >= iucv_pkg::EXT_LIMIT) begin
        err_next = iucv_pkg::ST_EXT_OPT;
      end else begin
        optn_next = optn_sum;
        if ({1'b0, byte_position} + 18'd1 + {14'd0, ln} > {1'b0, opt_end}) begin
          err_next = iucv_pkg::ST_OPT_TRUNC;
        end else if (ln != 4'd0) begin
          left_next = ln;
          idx_next = 4'd0;
          if (optn_sum == iucv_pkg::URI_PATH) begin
            if (ln == 4'd6) flags_next[2] = 1'b1;
            if (ln == 4'd4) flags_next[3] = 1'b1;
          end
        end
      end
    end
  end

  // packet state and summary register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0; first_error <= '0; ip_payload_length <= '0;
      sport <= '0; dport <= '0; ulen <= '0; hop <= '0; code <= '0; msg_id <= '0;
      option_number <= '0; option_bytes_left <= '0; option_value_index <= '0;
      match_flags <= '0; payload_start <= '0; sum_valid <= 1'b0;
    end else begin
      sum_valid <= 1'b0;
      if (take) begin
        if (last_byte) begin
          sum_valid <= 1'b1;
          sum.total <= pos_inc;
          sum.first_error <= err_next;
          sum.ip_payload_length <= (byte_position == 17'd4) ? {data_byte, 8'd0} :
            (byte_position == 17'd5) ? {ip_payload_length[15:8], data_byte} : ip_payload_length;
          sum.saw_both <= flags_next[0] & flags_next[1];
          sum.payload_start <= pstart_next;
          sum.source_port <= (byte_position == 17'd40) ? {data_byte, 8'd0} :
            (byte_position == 17'd41) ? {sport[15:8], data_byte} : sport;
          sum.destination_port <= (byte_position == 17'd42) ? {data_byte, 8'd0} :
            (byte_position == 17'd43) ? {dport[15:8], data_byte} : dport;
          sum.udp_length <= (byte_position == 17'd44) ? {data_byte, 8'd0} :
            (byte_position == 17'd45) ? {ulen[15:8], data_byte} : ulen;
          sum.hop_count <= (byte_position == 17'd7) ? data_byte : hop;
          sum.coap_code <= (byte_position == 17'd49) ? data_byte : code;
          sum.message_id <= (byte_position == 17'd50) ? {data_byte, 8'd0} :
            (byte_position == 17'd51) ? {msg_id[15:8], data_byte} : msg_id;
          byte_position <= '0; first_error <= '0; ip_payload_length <= '0;
          sport <= '0; dport <= '0; ulen <= '0; hop <= '0; code <= '0; msg_id <= '0;
          option_number <= '0; option_bytes_left <= '0; option_value_index <= '0;
          match_flags <= '0; payload_start <= '0;
        end else begin
          byte_position <= pos_inc;
          first_error <= err_next;
          option_number <= optn_next;
          option_bytes_left <= left_next;
          option_value_index <= idx_next;
          match_flags <= flags_next;
          payload_start <= pstart_next;
          case (byte_position)
            17'd4: ip_payload_length <= {data_byte, 8'd0};
            17'd5: ip_payload_length[7:0] <= data_byte;
            17'd7: hop <= data_byte;
            17'd40: sport <= {data_byte, 8'd0};
            17'd41: sport[7:0] <= data_byte;
            17'd42: dport <= {data_byte, 8'd0};
            17'd43: dport[7:0] <= data_byte;
            17'd44: ulen <= {data_byte, 8'd0};
            17'd45: ulen[7:0] <= data_byte;
            17'd49: code <= data_byte;
            17'd50: msg_id <= {data_byte, 8'd0};
            17'd51: msg_id[7:0] <= data_byte;
            default: ;
          endcase
        end
      end
    end
  end

  // a summary only ever follows a word that carried the last mark
  assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> $past(take && last_byte)) else $error("summary without last word");
  assert property (@(posedge clk) disable iff (rst)
    (take && last_byte) |=> byte_position == 17'd0) else $error("position not cleared");
  assert property (@(posedge clk) disable iff (rst)
    option_bytes_left == 4'd0 |-> match_flags[3:2] == 2'b00)
    else $error("stale candidate flags");
endmodule
`default_nettype wire

@@ hdl/iucv_back.sv @@
// back end: summary queue, final verdict and output register
`timescale 1ns / 1ps
`default_nettype none
module iucv_back (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     sum_valid,
  input  iucv_pkg::summary_t      sum,
  input  wire  [7:0]              expected_payload_size,
  output logic                    queue_full,
  output logic                    out_valid,
  input  wire                     out_stall,
  output iucv_pkg::result_t       res
);
  // two-entry queue of finished packets
  iucv_pkg::summary_t q [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        pop, push;
  iucv_pkg::summary_t h;
  logic [16:0] qend;
  logic [3:0]  status;
  logic [16:0] plen;

  assign push = sum_valid;
  assign pop = (count != 2'd0) && (!out_valid || !out_stall);
  // front may take a last word only while a slot is free after this edge
  assign queue_full = (count == 2'd2) || (count == 2'd1 && sum_valid && !pop);
  assign h = q[rd_ptr];
  assign qend = iucv_pkg::IP_HDR_BYTES + {1'b0, h.udp_length};

  // final verdict, earliest failing check first
  always_comb begin
    plen = (h.payload_start != 17'd0 && h.payload_start <= qend) ?
           qend - h.payload_start : 17'd0;
    if (h.total < iucv_pkg::MIN_PACKET) status = iucv_pkg::ST_SHORT;
    else if (h.first_error == iucv_pkg::ST_VERSION || h.first_error == iucv_pkg::ST_NOT_UDP)
      status = h.first_error;
    else if (h.total < iucv_pkg::IP_HDR_BYTES + {1'b0, h.ip_payload_length})
      status = iucv_pkg::ST_IP_TRUNC;
    else if (h.udp_length < 16'd8) status = iucv_pkg::ST_UDP_LEN;
    else if (qend > h.total) status = iucv_pkg::ST_UDP_TRUNC;
    else if (h.udp_length < 16'd12) status = iucv_pkg::ST_COAP_SHORT;
    else if (h.first_error != iucv_pkg::ST_OK) status = h.first_error;
    else if (!h.saw_both) status = iucv_pkg::ST_URI;
    else if (plen != {9'd0, expected_payload_size}) status = iucv_pkg::ST_PAYLOAD;
    else status = iucv_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= sum;
    if (pop) begin
      res.status <= status;
      res.source_port <= h.source_port;
      res.destination_port <= h.destination_port;
      res.udp_length <= h.udp_length;
      res.hop_count <= h.hop_count;
      res.coap_code <= h.coap_code;
      res.message_id <= h.message_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0; out_valid <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
      if (pop) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !(push && count == 2'd2)) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid) else $error("popped word not shown");
  assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
endmodule
`default_nettype wire

@@ hdl/ipv6_udp_coap_packet_validator.sv @@
// top level of the ipv6/udp/coap packet validator
//
// input channel: one packet byte per word (data_byte, last_byte) under
// in_valid / in_stall; a word is taken when in_valid is high and in_stall low.
// output channel: one result word per packet (status and captured header
// fields) under out_valid / out_stall, given for the word that had last_byte.
// throughput: one byte per cycle while in_stall is low; every byte needs
// only position compares and the option walk, done in the front end in the
// cycle it arrives. the front summary register loads as the last byte is
// taken; the result then passes a queue slot and the result register.
// a two-entry summary queue decouples the two ends; in_stall holds every
// byte while the queue has no room left for another finished packet.
// reset (rst, synchronous) clears all packet state, empties the queue and
// sets expected_payload_size to 12. while out_stall holds, the shown result
// stays put and the front keeps taking bytes until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module ipv6_udp_coap_packet_validator (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  data_byte,
  input  wire         last_byte,
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  status,
  output logic [15:0] source_port,
  output logic [15:0] destination_port,
  output logic [15:0] udp_length,
  output logic [7:0]  hop_count,
  output logic [7:0]  coap_code,
  output logic [15:0] message_id
);
  logic [7:0] expected_payload_size;
  logic queue_full, take, sum_valid;
  iucv_pkg::summary_t sum;
  iucv_pkg::result_t res;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) expected_payload_size <= 8'd12;
    else if (cfg_we) expected_payload_size <= cfg_wdata;
  end

  assign in_stall = queue_full;
  assign take = in_valid && !in_stall;

  iucv_front u_front (
    .clk(clk), .rst(rst), .data_byte(data_byte), .last_byte(last_byte),
    .take(take), .sum_valid(sum_valid), .sum(sum)
  );

  iucv_back u_back (
    .clk(clk), .rst(rst), .sum_valid(sum_valid), .sum(sum),
    .expected_payload_size(expected_payload_size), .queue_full(queue_full),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign status = res.status;
  assign source_port = res.source_port;
  assign destination_port = res.destination_port;
  assign udp_length = res.udp_length;
  assign hop_count = res.hop_count;
  assign coap_code = res.coap_code;
  assign message_id = res.message_id;
endmodule
`default_nettype wire

@@ test/ipv6_udp_coap_packet_validator_test.sv @@
// self-checking testbench for the ipv6/udp/coap packet validator
`timescale 1ns / 1ps
`default_nettype none
module ipv6_udp_coap_packet_validator_test;

  // kinds of packet damage applied by the packet builder
  typedef enum int {
    M_NONE, M_SHORT, M_VERSION, M_NEXT_HDR, M_IP_TRUNC, M_UDP_LEN, M_UDP_TRUNC,
    M_COAP_SHORT, M_COAP_HDR, M_EXT_OPT, M_OPT_TRUNC, M_URI, M_PAYLOAD, M_FLIP,
    M_TRAILER, M_NO_MARKER
  } damage_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  status;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [15:0] udp_length;
  logic [7:0]  hop_count;
  logic [7:0]  coap_code;
  logic [15:0] message_id;

  ipv6_udp_coap_packet_validator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .source_port(source_port), .destination_port(destination_port),
    .udp_length(udp_length), .hop_count(hop_count), .coap_code(coap_code),
    .message_id(message_id)
  );

  word_t             byte_q[$];
  iucv_pkg::result_t verdict_q[$];
  word_t             cur_word;
  int                idle_cnt = 0;
  int                stall_cnt = 0;
  bit                mon_quiet = 1'b0;
  int                fails = 0;
  string             sensor_word = "sensor";
  string             data_word = "data";

  // predictor copy of the packet state and register
  int unsigned pos_cnt, pay_start, opt_left, opt_idx;
  logic [3:0]  err_code;
  logic [15:0] ip_len, sport, dport, ulen_f, mid, opt_num;
  logic [7:0]  nxt_hdr, hop, code, size_cfg;
  bit          saw_s, saw_d, cand_s, cand_d;

  function automatic void clear_tracking();
    pos_cnt = 0; pay_start = 0; opt_left = 0; opt_idx = 0; err_code = iucv_pkg::ST_OK;
    ip_len = 0; sport = 0; dport = 0; ulen_f = 0; mid = 0; opt_num = 0;
    nxt_hdr = 0; hop = 0; code = 0;
    saw_s = 0; saw_d = 0; cand_s = 0; cand_d = 0;
  endfunction

  function automatic void flag_error(input logic [3:0] c);
    if (err_code == iucv_pkg::ST_OK) err_code = c;
  endfunction

  // advance the predicted parse by one accepted byte
  function automatic void track_byte(input logic [7:0] b, input logic lst);
    int unsigned pos, endp, delta, len, k, plen;
    iucv_pkg::result_t r;
    pos = pos_cnt;
    case (pos)
      0: if (b[7:4] != 4'd6) flag_error(iucv_pkg::ST_VERSION);
      4: ip_len[15:8] = b;
      5: ip_len[7:0] = b;
      6: begin
        nxt_hdr = b;
        if (b != iucv_pkg::UDP_PROTO) flag_error(iucv_pkg::ST_NOT_UDP);
      end
      7: hop = b;
      40: sport[15:8] = b;
      41: sport[7:0] = b;
      42: dport[15:8] = b;
      43: dport[7:0] = b;
      44: ulen_f[15:8] = b;
      45: ulen_f[7:0] = b;
      48: if (b != 8'h50) flag_error(iucv_pkg::ST_COAP_HDR);
      49: code = b;
      50: mid[15:8] = b;
      51: mid[7:0] = b;
      default: ;
    endcase
    endp = 40 + ulen_f;
    // option walk up to the marker
    if (pos >= 52 && err_code == iucv_pkg::ST_OK && pay_start == 0 && pos < endp) begin
      if (opt_left != 0) begin
        k = opt_idx;
        if (cand_s && (k >= 6 || b != sensor_word[k])) cand_s = 0;
        if (cand_d && (k >= 4 || b != data_word[k])) cand_d = 0;
        opt_idx = (k + 1) & 15;
        opt_left--;
        if (opt_left == 0) begin
          saw_s |= cand_s;
          saw_d |= cand_d;
          cand_s = 0;
          cand_d = 0;
        end
      end else if (b == iucv_pkg::MARKER_BYTE) begin
        pay_start = pos + 1;
      end else begin
        delta = b[7:4];
        len = b[3:0];
        if (delta >= 13 || len >= 13) flag_error(iucv_pkg::ST_EXT_OPT);
        else begin
          opt_num = 16'(opt_num + delta);
          if (pos + 1 + len > endp) flag_error(iucv_pkg::ST_OPT_TRUNC);
          else if (len != 0) begin
            opt_left = len;
            opt_idx = 0;
            if (opt_num == iucv_pkg::URI_PATH) begin
              if (len == 6) cand_s = 1;
              if (len == 4) cand_d = 1;
            end
          end
        end
      end
    end
    pos_cnt = (pos < 131071) ? pos + 1 : 131071;
    if (lst) begin
      plen = (pay_start != 0 && pay_start <= endp) ? endp - pay_start : 0;
      if (pos_cnt < 52) r.status = iucv_pkg::ST_SHORT;
      else if (err_code == iucv_pkg::ST_VERSION || err_code == iucv_pkg::ST_NOT_UDP)
        r.status = err_code;
      else if (pos_cnt < 40 + ip_len) r.status = iucv_pkg::ST_IP_TRUNC;
      else if (ulen_f < 8) r.status = iucv_pkg::ST_UDP_LEN;
      else if (endp > pos_cnt) r.status = iucv_pkg::ST_UDP_TRUNC;
      else if (ulen_f - 8 < 4) r.status = iucv_pkg::ST_COAP_SHORT;
      else if (err_code != iucv_pkg::ST_OK) r.status = err_code;
      else if (!(saw_s && saw_d)) r.status = iucv_pkg::ST_URI;
      else if (plen != size_cfg) r.status = iucv_pkg::ST_PAYLOAD;
      else r.status = iucv_pkg::ST_OK;
      r.source_port = sport;
      r.destination_port = dport;
      r.udp_length = ulen_f;
      r.hop_count = hop;
      r.coap_code = code;
      r.message_id = mid;
      verdict_q.push_back(r);
      clear_tracking();
    end
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // driver: present queued bytes, waiting each word's gap first
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_cnt = 0;
    end else begin
      if (in_valid && !in_stall) track_byte(data_byte, last_byte);
      if (!in_valid || !in_stall) begin
        if (byte_q.size() == 0) in_valid <= 1'b0;
        else if (idle_cnt < byte_q[0].gap) begin
          idle_cnt++;
          in_valid <= 1'b0;
        end else begin
          cur_word = byte_q.pop_front();
          data_byte <= cur_word.data;
          last_byte <= cur_word.last;
          in_valid <= 1'b1;
          idle_cnt = 0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) report("unexpected result, status", status, 0);
        else begin
          if (status != verdict_q[0].status) report("status", status, verdict_q[0].status);
          if (source_port != verdict_q[0].source_port)
            report("source_port", source_port, verdict_q[0].source_port);
          if (destination_port != verdict_q[0].destination_port)
            report("destination_port", destination_port, verdict_q[0].destination_port);
          if (udp_length != verdict_q[0].udp_length)
            report("udp_length", udp_length, verdict_q[0].udp_length);
          if (hop_count != verdict_q[0].hop_count)
            report("hop_count", hop_count, verdict_q[0].hop_count);
          if (coap_code != verdict_q[0].coap_code)
            report("coap_code", coap_code, verdict_q[0].coap_code);
          if (message_id != verdict_q[0].message_id)
            report("message_id", message_id, verdict_q[0].message_id);
          void'(verdict_q.pop_front());
        end
        stall_cnt = mon_quiet ? 0 : $urandom_range(0, 9);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // build one packet, damage it as asked and queue its bytes
  task automatic send_packet(input damage_t m, input int psize, input bit quiet);
    logic [7:0] p[$];
    int uri_at[$];
    int ulen, plen, hdr_s, d, l, i, n;
    bit sfirst, is_s;
    p = {};
    p.push_back({4'h6, 4'($urandom)});
    for (i = 0; i < 3; i++) p.push_back(8'($urandom));
    p.push_back(8'd0);
    p.push_back(8'd0);
    p.push_back(iucv_pkg::UDP_PROTO);
    for (i = 0; i < 33; i++) p.push_back(8'($urandom));
    for (i = 0; i < 4; i++) p.push_back(8'($urandom));
    p.push_back(8'd0);
    p.push_back(8'd0);
    p.push_back(8'($urandom));
    p.push_back(8'($urandom));
    p.push_back(8'h50);
    for (i = 0; i < 3; i++) p.push_back(8'($urandom));
    if (m == M_EXT_OPT) begin
      if ($urandom_range(0, 1)) p.push_back({4'($urandom_range(13, 15)), 4'($urandom_range(0, 14))});
      else p.push_back({4'($urandom_range(0, 14)), 4'($urandom_range(13, 15))});
    end
    // optional option below uri-path
    n = 0;
    if ($urandom_range(0, 1)) begin
      d = $urandom_range(0, 10);
      l = $urandom_range(0, 3);
      p.push_back({4'(d), 4'(l)});
      for (i = 0; i < l; i++) p.push_back(8'($urandom));
      n = d;
    end
    // two uri-path segments in either order
    sfirst = $urandom_range(0, 1);
    hdr_s = 0;
    for (d = 0; d < 2; d++) begin
      is_s = ((d == 0) == sfirst);
      if (is_s) hdr_s = p.size();
      l = is_s ? 6 : 4;
      p.push_back({4'(d == 0 ? 11 - n : 0), 4'(l)});
      for (i = 0; i < l; i++) begin
        uri_at.push_back(p.size());
        p.push_back(is_s ? sensor_word[i] : data_word[i]);
      end
    end
    if ($urandom_range(0, 1)) begin
      l = $urandom_range(0, 3);
      p.push_back({4'($urandom_range(1, 12)), 4'(l)});
      for (i = 0; i < l; i++) p.push_back(8'($urandom));
    end
    // marker and payload
    if (m == M_PAYLOAD) begin
      n = psize + ($urandom_range(0, 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3));
      if (n < 0) n = psize + 2;
    end else n = psize;
    if (m != M_NO_MARKER) p.push_back(iucv_pkg::MARKER_BYTE);
    for (i = 0; i < n; i++) p.push_back(8'($urandom));
    ulen = p.size() - 40;
    plen = ulen;
    case (m)
      M_VERSION: p[0][7:4] = 4'(6 + $urandom_range(1, 15));
      M_NEXT_HDR: p[6] = 8'(17 + $urandom_range(1, 255));
      M_IP_TRUNC: plen = ulen + $urandom_range(1, 300);
      M_UDP_LEN: begin
        ulen = $urandom_range(0, 7);
        plen = ulen;
      end
      M_UDP_TRUNC: ulen = ulen + $urandom_range(1, 20);
      M_COAP_SHORT: begin
        ulen = $urandom_range(8, 11);
        plen = ulen;
      end
      M_COAP_HDR: p[48] = 8'h50 ^ 8'($urandom_range(1, 255));
      M_OPT_TRUNC: begin
        ulen = hdr_s + 1 + $urandom_range(0, 5) - 40;
        plen = ulen;
      end
      M_URI: begin
        i = uri_at[$urandom_range(0, uri_at.size() - 1)];
        p[i] = p[i] ^ (8'd1 << $urandom_range(0, 7));
      end
      M_FLIP: p[$urandom_range(0, p.size() - 1)] = 8'($urandom);
      M_TRAILER: begin
        l = $urandom_range(1, 6);
        for (i = 0; i < l; i++) p.push_back(8'($urandom));
      end
      default: ;
    endcase
    p[4] = 8'(plen >> 8);
    p[5] = 8'(plen);
    p[44] = 8'(ulen >> 8);
    p[45] = 8'(ulen);
    if (m == M_SHORT) begin
      n = $urandom_range(1, 51);
      while (p.size() > n) void'(p.pop_back());
    end
    for (i = 0; i < p.size(); i++)
      byte_q.push_back('{p[i], i == p.size() - 1, quiet ? 0 : $urandom_range(0, 9)});
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_size(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_cfg = v;
  endtask

  // stimulus phases
  initial begin
    logic [7:0] sizes[2];
    int ph, j;
    sizes = '{8'd0, 8'd255};
    clear_tracking();
    size_cfg = 8'd12;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < 2; ph++) begin
      wait_idle();
      write_size(sizes[ph]);
      mon_quiet = (ph == 1);
      if (ph == 0) begin
        // directed: each damage kind once
        for (j = M_NONE; j <= M_NO_MARKER; j++) send_packet(damage_t'(j), size_cfg, 0);
        // one-byte packets back to back to fill the summary queue
        for (j = 0; j < 12; j++) byte_q.push_back('{8'($urandom), 1'b1, 0});
      end else send_packet(M_NONE, size_cfg, 1);
    end
    wait_idle();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hdl/iucv_pkg.sv
hdl/iucv_front.sv
hdl/iucv_back.sv
hdl/ipv6_udp_coap_packet_validator.sv
test/ipv6_udp_coap_packet_validator_test.sv
